// File: rtl/core/assert_macros.svh
// Assertion macros for the receiver's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion. It is off while reset is asserted.
`define CRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/crf_pkg.sv
// Types, constants and helpers for the checksummed frame receiver.
package crf_pkg;

  // Frame limits
  localparam int unsigned MaxFrame  = 64;
  localparam int unsigned MaxFields = 12;
  localparam int unsigned MinFrame  = 7;

  localparam int unsigned CntW   = $clog2(MaxFrame + 1);  // length and count width
  localparam int unsigned AddrW  = $clog2(MaxFrame);      // payload store index
  localparam int unsigned ComW   = 4;                     // saturating comma count
  localparam int unsigned TposW  = 3;                     // saturating trailer position

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;                  // status + byte, byte padded

  localparam logic [CntW-1:0]  MaxFrameC  = CntW'(MaxFrame);
  localparam logic [CntW-1:0]  MinFrameC  = CntW'(MinFrame);
  localparam logic [ComW-1:0]  MaxFieldsC = ComW'(MaxFields);
  localparam logic [ComW-1:0]  ComSat     = '1;
  localparam logic [TposW-1:0] TposSat    = '1;

  // Characters
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatChecksum = 2'd1,
    StatFormat   = 2'd2,
    StatOverflow = 2'd3
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StRecv = 1'b1
  } parse_state_e;

  // Frame outcome handed from the parser to the drain
  typedef struct packed {
    logic            start;
    logic            good;
    status_e         status;
    logic [CntW-1:0] count;
  } crf_job_t;

  // Hex digit value, bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

// File: rtl/core/crf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module crf_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/crf_parser.sv
// Frame parser: tracks the frame, writes payload bytes, judges the frame at LF.
module crf_parser import crf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,     // byte accepted this cycle
  input  logic [7:0]       byte_i,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [7:0]       wdata_o,
  output crf_job_t         job_o
);

  parse_state_e     state_q, state_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  flen_q, flen_d;
  logic [CntW-1:0]  pcnt_q, pcnt_d;
  logic [7:0]       xor_q, xor_d;
  logic             star_q, star_d;
  logic [TposW-1:0] tpos_q, tpos_d;
  logic [7:0]       tck_q, tck_d;
  logic             tbad_q, tbad_d;
  logic [ComW-1:0]  com_q, com_d;

  logic       is_dollar, is_lf;
  logic [4:0] nib;

  assign is_dollar = (byte_i == ChDollar);
  assign is_lf     = (byte_i == ChLf);
  assign nib       = hex_value(byte_i);

  // next state
  always_comb begin
    state_d = state_q;
    if (acc_i) begin
      if (is_dollar) begin
        state_d = StRecv;
      end else if (state_q == StRecv && is_lf) begin
        state_d = StIdle;
      end
    end
  end

  // frame bookkeeping and outcome
  always_comb begin
    ovf_d   = ovf_q;
    flen_d  = flen_q;
    pcnt_d  = pcnt_q;
    xor_d   = xor_q;
    star_d  = star_q;
    tpos_d  = tpos_q;
    tck_d   = tck_q;
    tbad_d  = tbad_q;
    com_d   = com_q;
    we_o    = 1'b0;
    job_o   = '0;
    job_o.status = StatOk;

    if (acc_i) begin
      if (is_dollar) begin
        ovf_d  = 1'b0;
        flen_d = CntW'(1);
        pcnt_d = '0;
        xor_d  = '0;
        star_d = 1'b0;
        tpos_d = '0;
        tck_d  = '0;
        tbad_d = 1'b0;
        com_d  = '0;
      end else if (state_q == StRecv) begin
        if (flen_q >= MaxFrameC) begin
          ovf_d = 1'b1;                     // byte dropped
        end else begin
          flen_d = flen_q + CntW'(1);
          if (!star_q) begin
            if (byte_i == ChStar) begin
              star_d = 1'b1;
              tpos_d = '0;
            end else begin
              we_o   = 1'b1;
              pcnt_d = pcnt_q + CntW'(1);
              xor_d  = xor_q ^ byte_i;
              if (byte_i == ChComma && com_q != ComSat) begin
                com_d = com_q + ComW'(1);
              end
            end
          end else begin
            // trailer: two hex digits, then CR LF or LF
            unique case (tpos_q) inside
              TposW'(0), TposW'(1): begin
                if (nib[4]) tbad_d = 1'b1;
                else        tck_d  = {tck_q[3:0], nib[3:0]};
              end
              TposW'(2): begin
                if (byte_i != ChCr && byte_i != ChLf) tbad_d = 1'b1;
              end
              TposW'(3): begin
                if (!is_lf) tbad_d = 1'b1;
              end
              default: tbad_d = 1'b1;
            endcase
            if (tpos_q != TposSat) tpos_d = tpos_q + TposW'(1);
          end
        end

        if (is_lf) begin
          job_o.start = 1'b1;
          job_o.count = pcnt_d;
          if (ovf_d) begin
            job_o.status = StatOverflow;
          end else if (flen_d < MinFrameC || !star_d || tbad_d ||
                       (tpos_d != TposW'(3) && tpos_d != TposW'(4))) begin
            job_o.status = StatFormat;
          end else if (xor_d != tck_d) begin
            job_o.status = StatChecksum;
          end else if (pcnt_d == '0 || com_d >= MaxFieldsC) begin
            job_o.status = StatFormat;
          end else begin
            job_o.good = 1'b1;
          end
          ovf_d = 1'b0;
        end
      end
    end
  end

  assign waddr_o = pcnt_q[AddrW-1:0];
  assign wdata_o = byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovf_q   <= 1'b0;
      flen_q  <= '0;
      pcnt_q  <= '0;
      xor_q   <= '0;
      star_q  <= 1'b0;
      tpos_q  <= '0;
      tck_q   <= '0;
      tbad_q  <= 1'b0;
      com_q   <= '0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      flen_q  <= flen_d;
      pcnt_q  <= pcnt_d;
      xor_q   <= xor_d;
      star_q  <= star_d;
      tpos_q  <= tpos_d;
      tck_q   <= tck_d;
      tbad_q  <= tbad_d;
      com_q   <= com_d;
    end
  end

endmodule

// File: rtl/core/crf_drain.sv
// Result drain: payload read-back or status beat into the output register.
module crf_drain import crf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crf_job_t            job_i,
  output logic                busy_o,
  output logic                re_o,
  output logic [AddrW-1:0]    raddr_o,
  input  logic [7:0]          rdata_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tuser_o,
  output logic                m_tlast_o
);

  logic [CntW-1:0]  rem_q, rem_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             spend_q, spend_d;
  status_e          stat_q, stat_d;

  // stage 1: RAM read register plus its side information
  logic    s1_vld_q, s1_vld_d;
  logic    s1_byte_q, s1_byte_d;
  logic    s1_last_q, s1_last_d;
  status_e s1_stat_q, s1_stat_d;

  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_user_q, out_last_q;

  logic adv, s1_free, rd_issue, st_issue;

  assign adv      = !out_vld_q || m_tready_i;
  assign s1_free  = !s1_vld_q || adv;
  assign rd_issue = (rem_q != '0) && s1_free;
  assign st_issue = spend_q && s1_free;

  assign re_o    = rd_issue;
  assign raddr_o = ptr_q;
  assign busy_o  = (rem_q != '0) || spend_q || s1_vld_q;

  always_comb begin
    rem_d     = rem_q;
    ptr_d     = ptr_q;
    spend_d   = spend_q;
    stat_d    = stat_q;
    s1_vld_d  = s1_vld_q;
    s1_byte_d = s1_byte_q;
    s1_last_d = s1_last_q;
    s1_stat_d = s1_stat_q;

    // jobs only arrive while idle
    if (job_i.start) begin
      if (job_i.good) begin
        rem_d = job_i.count;
        ptr_d = '0;
      end else begin
        spend_d = 1'b1;
        stat_d  = job_i.status;
      end
    end

    if (rd_issue) begin
      rem_d     = rem_q - CntW'(1);
      ptr_d     = ptr_q + AddrW'(1);
      s1_vld_d  = 1'b1;
      s1_byte_d = 1'b1;
      s1_last_d = (rem_q == CntW'(1));
      s1_stat_d = StatOk;
    end else if (st_issue) begin
      spend_d   = 1'b0;
      s1_vld_d  = 1'b1;
      s1_byte_d = 1'b0;
      s1_last_d = 1'b1;
      s1_stat_d = stat_q;
    end else if (adv) begin
      s1_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      ptr_q     <= '0;
      spend_q   <= 1'b0;
      stat_q    <= StatOk;
      s1_vld_q  <= 1'b0;
      s1_byte_q <= 1'b0;
      s1_last_q <= 1'b0;
      s1_stat_q <= StatOk;
      out_vld_q <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      ptr_q     <= ptr_d;
      spend_q   <= spend_d;
      stat_q    <= stat_d;
      s1_vld_q  <= s1_vld_d;
      s1_byte_q <= s1_byte_d;
      s1_last_q <= s1_last_d;
      s1_stat_q <= s1_stat_d;
      if (adv) out_vld_q <= s1_vld_q;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {(OutDataW - 10)'(0), (s1_byte_q ? rdata_i : 8'h00), s1_stat_q};
      out_user_q <= s1_byte_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

endmodule

// File: rtl/core/checksummed_frame_receiver.sv
// Top level of the checksummed frame receiver.
// Usage:
// - Slave stream: one received byte per beat on s_axis_tdata_i[7:0]. '$' opens or
//   reopens a frame, bytes outside a frame are dropped, the first LF closes it.
// - Master stream: one result per beat. tdata[1:0] status (ok, checksum, format,
//   overflow), tdata[9:2] payload byte; tuser marks a payload beat; tlast marks
//   the final beat of a frame.
// - A good frame gives its payload bytes as a run; a bad one gives one status beat.
// - Throughput: one byte a cycle while no results are pending. After the closing
//   LF the slave side holds tready low until every result of that frame has left
//   the read stage, one result a cycle unless the master side stalls, paced by the
//   payload RAM read port. Each result passes the read stage, then the output
//   register.
// - A stalled master side holds the output register; the drain waits behind it
//   and the byte input stays blocked until the drain empties.
// - Reset clears all control state; the payload RAM needs no clearing since only
//   entries written in the current frame are ever read.
module checksummed_frame_receiver import crf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [1:0] status, [9:2] payload_byte
  output logic                m_axis_tuser_o,   // byte_present
  output logic                m_axis_tlast_o    // last_of_run
);

`include "assert_macros.svh"

  logic             acc;
  logic             drn_busy;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  crf_job_t         job;

  // bytes are held off while a frame's results drain
  assign s_axis_tready_o = !drn_busy;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  crf_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (s_axis_tdata_i[7:0]),
    .we_o    (ram_we),
    .waddr_o (ram_waddr),
    .wdata_o (ram_wdata),
    .job_o   (job)
  );

  // payload store, written by the parser, read back by the drain
  crf_ram #(
    .Depth (MaxFrame),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  crf_drain u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job),
    .busy_o     (drn_busy),
    .re_o       (ram_re),
    .raddr_o    (ram_raddr),
    .rdata_i    (ram_rdata),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  // the store is never written while it is read back
  `CRF_ASSERT(a_no_wr_in_drain, drn_busy |-> !ram_we, "payload write during drain")
  // a frame outcome only arrives with the drain idle
  `CRF_ASSERT(a_job_when_idle, job.start |-> !drn_busy, "frame ended while draining")
  // status beats stand alone and carry no byte
  `CRF_ASSERT(a_status_single,
              (m_axis_tvalid_o && !m_axis_tuser_o) |->
              (m_axis_tlast_o && m_axis_tdata_o[9:2] == 8'h00),
              "status beat malformed")
  // payload beats are always status ok
  `CRF_ASSERT(a_payload_ok,
              (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[1:0] == StatOk),
              "payload beat with error status")

endmodule

// File: bench/checksummed_frame_receiver_checker.sv
`timescale 1ns / 100ps
// Frame receiver result checker: predicts each frame's output beats and compares them.
module checksummed_frame_receiver_checker import crf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,   // [1:0] status, [9:2] payload_byte
  input  logic                m_axis_tuser_i,   // byte_present
  input  logic                m_axis_tlast_i,   // last_of_run
  output int                  mismatch_count_o,
  output int                  outstanding_o
);

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       present;
    logic       last;
  } frame_beat_t;

  frame_beat_t expected_q[$];

  // Predicted parser state
  logic             in_frame;
  logic             overrun;
  logic             star_seen;
  logic             trailer_bad;
  logic [CntW-1:0]  frame_len;
  logic [CntW-1:0]  payload_len;
  logic [7:0]       payload_xor;
  logic [7:0]       trailer_sum;
  logic [TposW-1:0] trailer_pos;
  logic [ComW-1:0]  comma_cnt;
  logic [7:0]       payload_mem [MaxFrame];

  // Nibble value of an ASCII hex digit; bit 4 flags a non-digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    return 5'h10;
  endfunction

  task automatic clear_frame();
    overrun     = 1'b0;
    star_seen   = 1'b0;
    trailer_bad = 1'b0;
    frame_len   = '0;
    payload_len = '0;
    payload_xor = '0;
    trailer_sum = '0;
    trailer_pos = '0;
    comma_cnt   = '0;
  endtask

  task automatic expect_status(input status_e st);
    frame_beat_t beat;
    beat.status  = st;
    beat.data    = '0;
    beat.present = 1'b0;
    beat.last    = 1'b1;
    expected_q.push_back(beat);
  endtask

  task automatic take_trailer(input logic [7:0] b);
    logic [4:0] nib;
    nib = nibble_of(b);
    if (trailer_pos < 2) begin
      if (nib[4]) trailer_bad = 1'b1;
      else trailer_sum = {trailer_sum[3:0], nib[3:0]};
    end else if (trailer_pos == 2) begin
      if (b != ChCr && b != ChLf) trailer_bad = 1'b1;
    end else if (trailer_pos == 3) begin
      if (b != ChLf) trailer_bad = 1'b1;
    end else begin
      trailer_bad = 1'b1;
    end
    if (trailer_pos != TposSat) trailer_pos = trailer_pos + TposW'(1);
  endtask

  // Advance the predicted parser by one received byte; a closing LF queues the results
  task automatic absorb_byte(input logic [7:0] b);
    frame_beat_t beat;
    if (b == ChDollar) begin
      clear_frame();
      in_frame  = 1'b1;
      frame_len = CntW'(1);
    end else if (in_frame) begin
      if (frame_len >= MaxFrameC) begin
        overrun = 1'b1;
      end else begin
        frame_len = frame_len + CntW'(1);
        if (star_seen) begin
          take_trailer(b);
        end else if (b == ChStar) begin
          star_seen   = 1'b1;
          trailer_pos = '0;
        end else begin
          payload_mem[payload_len[AddrW-1:0]] = b;
          payload_len = payload_len + CntW'(1);
          payload_xor = payload_xor ^ b;
          if (b == ChComma && comma_cnt != ComSat) comma_cnt = comma_cnt + ComW'(1);
        end
      end
      if (b == ChLf) begin
        in_frame = 1'b0;
        if (overrun) begin
          overrun = 1'b0;
          expect_status(StatOverflow);
        end else if (frame_len < MinFrameC || !star_seen || trailer_bad ||
                     (trailer_pos != 3 && trailer_pos != 4)) begin
          expect_status(StatFormat);
        end else if (payload_xor != trailer_sum) begin
          expect_status(StatChecksum);
        end else if (payload_len == 0 || comma_cnt >= MaxFieldsC) begin
          expect_status(StatFormat);
        end else begin
          for (int i = 0; i < payload_len; i++) begin
            beat.status  = StatOk;
            beat.data    = payload_mem[AddrW'(i)];
            beat.present = 1'b1;
            beat.last    = (i + 1 == payload_len);
            expected_q.push_back(beat);
          end
        end
      end
    end
  endtask

  task automatic report(input string field, input int want, input int got);
    mismatch_count_o++;
    $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  task automatic compare_beat();
    frame_beat_t want;
    if (expected_q.size() == 0) begin
      mismatch_count_o++;
      $display("%0t: beat expected none, got %0h", $time, m_axis_tdata_i);
    end else begin
      want = expected_q.pop_front();
      if (m_axis_tdata_i[1:0] !== want.status) report("status", want.status, m_axis_tdata_i[1:0]);
      if (m_axis_tdata_i[9:2] !== want.data) report("payload_byte", want.data, m_axis_tdata_i[9:2]);
      if (m_axis_tuser_i !== want.present) report("byte_present", want.present, m_axis_tuser_i);
      if (m_axis_tlast_i !== want.last) report("last_of_run", want.last, m_axis_tlast_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_frame();
      in_frame = 1'b0;
      expected_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) compare_beat();
      if (s_axis_tvalid_i && s_axis_tready_i) absorb_byte(s_axis_tdata_i[7:0]);
    end
    outstanding_o = expected_q.size();
  end

endmodule

// File: bench/checksummed_frame_receiver_tb.sv
`timescale 1ns / 100ps
// Testbench top for the checksummed frame receiver: byte stimulus, output stalls and verdict.
module checksummed_frame_receiver_tb import crf_pkg::*; ();

  // Stimulus stops once this many bytes have gone in
  localparam int TargetBytes   = 350;
  // Cycles without any beat on either side before giving up
  localparam int WatchdogLimit = 2000;
  // Settling time after the last result, well past the read latency
  localparam int DrainTail     = 20;

  typedef enum int unsigned {
    SentGood,
    SentBadSum,
    SentBadHex,
    SentNoStar,
    SentLongTrailer,
    SentShortTrailer,
    SentOverflow,
    SentManyCommas,
    SentRestart,
    SentGarbled
  } sentence_kind_e;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int rx_stall     = 0;
  int rx_gap;
  int frame_bytes  = 0;
  int noise_len;
  bit no_idle      = 1'b0;   // set for whole sentences to get back-to-back beats

  logic [7:0] sentence_q[$];

  always #10 clk_i = ~clk_i;

  checksummed_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  checksummed_frame_receiver_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tuser_i   (m_tuser),
    .m_axis_tlast_i   (m_tlast),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // Any byte that neither opens, splits nor closes a frame
  function automatic logic [7:0] payload_char(input int comma_pct);
    logic [7:0] c;
    if ($urandom_range(0, 99) < comma_pct) return ChComma;
    do c = 8'($urandom_range(0, 255)); while (c == ChDollar || c == ChStar || c == ChLf);
    return c;
  endfunction

  // Appends a payload; commas beyond the cap become letters. Returns its XOR.
  task automatic add_payload(input int len, input int comma_pct, input int comma_cap,
                             output logic [7:0] sum);
    logic [7:0] c;
    int commas;
    sum = '0;
    commas = 0;
    for (int i = 0; i < len; i++) begin
      c = payload_char(comma_pct);
      if (c == ChComma) begin
        if (commas >= comma_cap) c = 8'h41;
        else commas++;
      end
      sentence_q.push_back(c);
      sum ^= c;
    end
  endtask

  // '*', two hex digits in mixed case, then LF or CR LF
  task automatic add_trailer(input logic [7:0] sum);
    sentence_q.push_back(ChStar);
    sentence_q.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
    sentence_q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
    if ($urandom_range(0, 1)) sentence_q.push_back(ChCr);
    sentence_q.push_back(ChLf);
  endtask

  function automatic sentence_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return SentGood;
    if (r < 58) return SentBadSum;
    if (r < 64) return SentBadHex;
    if (r < 69) return SentNoStar;
    if (r < 74) return SentLongTrailer;
    if (r < 79) return SentShortTrailer;
    if (r < 83) return SentOverflow;
    if (r < 88) return SentManyCommas;
    if (r < 94) return SentRestart;
    return SentGarbled;
  endfunction

  // Mostly short payloads; some reach the longest frame that still fits
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 10);
    return $urandom_range(11, 59);
  endfunction

  task automatic build_sentence(input sentence_kind_e kind);
    int len;
    int pos;
    int comma_pct;
    logic [7:0] sum;
    logic [7:0] c;
    sentence_q.delete();
    // Line noise ahead of the frame, dropped by the block
    noise_len = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
    for (int i = 0; i < noise_len; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChDollar);
      sentence_q.push_back(c);
    end
    sentence_q.push_back(ChDollar);
    len = pick_len();
    comma_pct = ($urandom_range(0, 3) == 0) ? 40 : 5;
    case (kind)
      SentGood: begin
        add_payload(len, comma_pct, MaxFields - 1, sum);
        add_trailer(sum);
      end
      SentBadSum: begin
        add_payload(len, comma_pct, MaxFields - 1, sum);
        add_trailer(sum ^ 8'($urandom_range(1, 255)));
      end
      SentBadHex: begin
        add_payload(len, comma_pct, MaxFields - 1, sum);
        add_trailer(sum);
        pos = noise_len + 2 + len + $urandom_range(0, 1);
        do c = 8'($urandom_range(0, 255));
        while (c == ChDollar || c == ChLf || (c >= "0" && c <= "9") ||
               (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
        sentence_q[pos] = c;
      end
      SentNoStar: begin
        add_payload(len, comma_pct, MaxFields - 1, sum);
        if ($urandom_range(0, 1)) sentence_q.push_back(ChCr);
        sentence_q.push_back(ChLf);
      end
      SentLongTrailer: begin
        add_payload($urandom_range(1, 8), comma_pct, MaxFields - 1, sum);
        sentence_q.push_back(ChStar);
        sentence_q.push_back(hex_char(sum[7:4], 1'b0));
        sentence_q.push_back(hex_char(sum[3:0], 1'b1));
        repeat ($urandom_range(1, 5)) sentence_q.push_back(payload_char(0));
        sentence_q.push_back(ChLf);
      end
      SentShortTrailer: begin
        // covers the empty payload and frames under the minimum length
        add_payload($urandom_range(0, 6), comma_pct, MaxFields - 1, sum);
        sentence_q.push_back(ChStar);
        if ($urandom_range(0, 1)) sentence_q.push_back(hex_char(sum[7:4], 1'b0));
        sentence_q.push_back(ChLf);
      end
      SentOverflow: begin
        add_payload($urandom_range(58, 75), 5, MaxFields - 1, sum);
        add_trailer(sum);
      end
      SentManyCommas: begin
        // straddles the field limit from both sides
        add_payload($urandom_range(14, 30), 55, 15, sum);
        add_trailer(sum);
      end
      SentRestart: begin
        // abandoned frame, then a fresh '$' opens a good one
        repeat ($urandom_range(0, 8)) sentence_q.push_back(payload_char(10));
        sentence_q.push_back(ChDollar);
        add_payload(len, comma_pct, MaxFields - 1, sum);
        add_trailer(sum);
      end
      default: begin
        repeat ($urandom_range(0, 12)) begin
          do c = 8'($urandom_range(0, 255)); while (c == ChLf);
          sentence_q.push_back(c);
        end
        sentence_q.push_back(ChLf);
      end
    endcase
  endtask

  // One byte beat; tvalid stays high into the next beat when no gap follows
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_sentence();
    foreach (sentence_q[i]) send_byte(sentence_q[i]);
  endtask

  // Sender holds off until the block has handed over every predicted beat
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Output side: random stalls on tready, none begins while no_idle is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      rx_gap = pick_gap();
      m_tready <= (rx_gap == 0);
      rx_stall <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // Watchdog on beats: a hang on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("checksummed_frame_receiver_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored bytes outside a frame (including a stray LF), a good
    // frame closed by CR LF, the extreme payload bytes with lower-case hex,
    // and a frame one byte under the minimum length.
    sentence_q = '{8'h00, 8'hFF, ChLf,
                   ChDollar, 8'h41, 8'h42, ChStar, 8'h30, 8'h33, ChCr, ChLf,
                   ChDollar, 8'hFF, 8'h00, ChStar, 8'h66, 8'h66, ChLf,
                   ChDollar, ChComma, ChStar, 8'h32, 8'h43, ChLf};
    send_sentence();
    frame_bytes = sentence_q.size();
    wait_for_results();

    // Random sentences, mostly well formed with random content
    while (frame_bytes < TargetBytes) begin
      no_idle = ($urandom_range(0, 99) < 15);
      build_sentence(pick_kind());
      send_sentence();
      frame_bytes += sentence_q.size();
      if ($urandom_range(0, 99) < 8) wait_for_results();
    end
    no_idle = 1'b0;

    wait_for_results();
    repeat (DrainTail) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("checksummed_frame_receiver_tb OK");
    end else begin
      $display("checksummed_frame_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/crf_pkg.sv
rtl/core/crf_ram.sv
rtl/core/crf_parser.sv
rtl/core/crf_drain.sv
rtl/core/checksummed_frame_receiver.sv
bench/checksummed_frame_receiver_checker.sv
bench/checksummed_frame_receiver_tb.sv
